// ===== hw/rtl/pswd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pswd_pkg
// sizes, derived widths and controller states of the port scan detector
// ----------------------------------------------------------------------------
package pswd_pkg;

	localparam int SOURCES   = 16;
	localparam int ENTRIES   = 32;
	localparam int TIME_BITS = 32;
	localparam int PORT_BITS = 16;

	localparam int SRC_AW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
	localparam int EW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW     = $clog2(ENTRIES + 1);
	localparam int AW     = SRC_AW + EW;
	localparam int DW     = TIME_BITS + PORT_BITS;

	// configuration register indexes
	localparam logic REG_TIME_WINDOW = 1'b0;
	localparam logic REG_PORT_LIMIT  = 1'b1;

	// command codes
	localparam logic CMD_CONNECT = 1'b0;
	localparam logic CMD_QUERY   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_WR,
		ST_Q_RDI,
		ST_Q_STI,
		ST_Q_RDJ,
		ST_Q_CMPJ,
		ST_Q_EVAL,
		ST_RESP
	} state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/port_scan_window_detector_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// port_scan_window_detector_top
// per-source sorted connection tables in one memory, with insertion and
// sliding-window distinct-port scan driven by a read-modify-write sequencer
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | in_valid / in_ready    | cmd, source_id, port, timestamp
//  out     | out_valid / out_ready  | intruder, unknown_source, table_full
//  cfg     | cfg_wr_en              | cfg_index, cfg_data
//
//  one word in flight at a time. a connection compares entries one by one
//  while opening its sorted slot (one memory read port, registered read
//  data). a query scans, for each start entry, the entries in that window.
//  a full table, or a query on an empty source, answers without reading
//  the table. reset empties all tables at once through the per-source
//  counts, no clearing pass. a result waiting in the output register does
//  not stop the next word being accepted.
module port_scan_window_detector_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd,
	input  wire logic [3:0]  source_id,
	input  wire logic [15:0] port,
	input  wire logic [31:0] timestamp,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             intruder,
	output logic             unknown_source,
	output logic             table_full,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);
	import pswd_pkg::*;

	state_t state_q, state_d;

	// configuration
	logic [15:0] window_q, limit_q;

	// per-source fill counts
	logic [CW-1:0] count_q [SOURCES];

	// table memory: {time, port}
	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;
	logic [AW-1:0] raddr, waddr;
	logic [DW-1:0] wdata;
	logic          we;

	// latched word
	logic              cmd_q;
	logic [SRC_AW-1:0] src_q;
	logic [PORT_BITS-1:0] port_q;
	logic [TIME_BITS-1:0] ts_q;
	logic [CW-1:0]     n_q;

	// sequencer registers
	logic [CW-1:0]        pos_q, i_q, j_q, dcnt_q;
	logic [TIME_BITS-1:0] start_q;
	logic [PORT_BITS-1:0] seen_q [ENTRIES];
	logic                 res_int_q, res_unk_q, res_full_q;
	logic                 out_valid_q, out_int_q, out_unk_q, out_full_q;

	logic              accept;
	logic [SRC_AW-1:0] in_src;
	logic              src_ok;
	logic [CW-1:0]     in_n;
	logic [CW-1:0]     pos_m1, i_p1, j_p1, dcnt_p1;
	logic [TIME_BITS-1:0] r_time, diff;
	logic [PORT_BITS-1:0] r_port;
	logic              r_later, out_window, port_new, slot_free;

	assign in_src  = SRC_AW'(source_id);
	assign src_ok  = (32'(source_id) < SOURCES);
	assign in_n    = src_ok ? count_q[in_src] : '0;
	assign accept  = in_valid && in_ready;
	assign pos_m1  = pos_q - 1'b1;
	assign i_p1    = i_q + 1'b1;
	assign j_p1    = j_q + 1'b1;
	assign dcnt_p1 = dcnt_q + 1'b1;
	assign r_time  = rdata_q[DW-1:PORT_BITS];
	assign r_port  = rdata_q[PORT_BITS-1:0];
	assign r_later = (r_time > ts_q);
	// sorted table, so the difference never wraps
	assign diff       = r_time - start_q;
	assign out_window = (diff >= TIME_BITS'(window_q));
	assign slot_free  = !out_valid_q || out_ready;

	// distinct check against the ports already seen in this window
	always_comb begin
		port_new = 1'b1;
		for (int m = 0; m < ENTRIES; m++) begin
			if ((CW'(m) < dcnt_q) && (seen_q[m] == r_port))
				port_new = 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_CONNECT) begin
						if (!src_ok || in_n >= CW'(ENTRIES))
							state_d = ST_RESP;
						else if (in_n == '0)
							state_d = ST_INS_WR;
						else
							state_d = ST_INS_RD;
					end else begin
						state_d = (in_n == '0) ? ST_RESP : ST_Q_RDI;
					end
				end
			end
			ST_INS_RD:  state_d = ST_INS_CMP;
			ST_INS_CMP: begin
				if (r_later && pos_m1 != '0)
					state_d = ST_INS_RD;
				else
					state_d = ST_INS_WR;
			end
			ST_INS_WR: state_d = ST_RESP;
			ST_Q_RDI:  state_d = ST_Q_STI;
			ST_Q_STI:  state_d = ST_Q_RDJ;
			ST_Q_RDJ:  state_d = ST_Q_CMPJ;
			ST_Q_CMPJ: begin
				if (out_window || j_p1 == n_q)
					state_d = ST_Q_EVAL;
				else
					state_d = ST_Q_RDJ;
			end
			ST_Q_EVAL: begin
				if (32'(dcnt_q) >= 32'(limit_q))
					state_d = ST_RESP;
				else if (i_p1 == n_q)
					state_d = ST_RESP;
				else
					state_d = ST_Q_RDI;
			end
			ST_RESP: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		raddr    = {src_q, i_q[EW-1:0]};
		waddr    = {src_q, pos_q[EW-1:0]};
		wdata    = {ts_q, port_q};
		we       = 1'b0;
		case (state_q)
			ST_IDLE:    in_ready = 1'b1;
			ST_INS_RD:  raddr = {src_q, pos_m1[EW-1:0]};
			ST_INS_CMP: begin
				// shift the later entry up by one
				wdata = rdata_q;
				we    = r_later;
			end
			ST_INS_WR: we = 1'b1;
			ST_Q_RDI:  raddr = {src_q, i_q[EW-1:0]};
			ST_Q_RDJ:  raddr = {src_q, j_q[EW-1:0]};
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= 16'd1;
			limit_q     <= 16'd1;
			out_valid_q <= 1'b0;
			for (int s = 0; s < SOURCES; s++)
				count_q[s] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				if (cfg_index == REG_TIME_WINDOW)
					window_q <= cfg_data;
				else
					limit_q <= cfg_data;
			end
			if (state_q == ST_INS_WR)
				count_q[src_q] <= n_q + 1'b1;
			if (state_q == ST_RESP && slot_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q      <= cmd;
					src_q      <= in_src;
					port_q     <= port;
					ts_q       <= TIME_BITS'(timestamp);
					n_q        <= in_n;
					pos_q      <= in_n;
					i_q        <= '0;
					res_int_q  <= 1'b0;
					res_unk_q  <= (cmd == CMD_QUERY) && (in_n == '0);
					res_full_q <= (cmd == CMD_CONNECT) && src_ok &&
						(in_n >= CW'(ENTRIES));
				end
			end
			ST_INS_CMP: begin
				if (r_later)
					pos_q <= pos_m1;
			end
			ST_Q_STI: begin
				start_q <= r_time;
				j_q     <= i_q;
				dcnt_q  <= '0;
			end
			ST_Q_CMPJ: begin
				if (!out_window) begin
					if (port_new) begin
						seen_q[dcnt_q[EW-1:0]] <= r_port;
						dcnt_q <= dcnt_p1;
					end
					j_q <= j_p1;
				end
			end
			ST_Q_EVAL: begin
				if (32'(dcnt_q) >= 32'(limit_q))
					res_int_q <= 1'b1;
				i_q <= i_p1;
			end
			ST_RESP: begin
				if (slot_free) begin
					out_int_q  <= res_int_q && (cmd_q == CMD_QUERY);
					out_unk_q  <= res_unk_q;
					out_full_q <= res_full_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign intruder       = out_int_q;
	assign unknown_source = out_unk_q;
	assign table_full     = out_full_q;

endmodule
`default_nettype wire
